FILE: rtl/core/huffman_code_builder_core_assert.svh
// Assertion macros shared by the code builder RTL.
`ifndef HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_CORE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define HCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen out of reset.
`define HCB_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/hcb_pkg.sv
// Shared types and constants of the code builder.
package hcb_pkg;

    localparam int MaxSymbols = 32;
    localparam int WeightBits = 24;
    localparam int SymBits    = 8;
    localparam int LenBits    = 5;
    localparam int CodeBits   = 31;

    typedef struct packed {
        logic [SymBits-1:0]    symbol;
        logic [WeightBits-1:0] weight;
        logic                  last_symbol;
    } t_in_item;

    typedef struct packed {
        logic [SymBits-1:0]  out_symbol;
        logic [LenBits-1:0]  code_length;
        logic [CodeBits-1:0] code_bits;
        logic                last_code;
        logic                overflow;
    } t_out_item;

    // Requests from the sequencer to the heap engine.
    typedef struct packed {
        logic push;
        logic pop;
    } t_heap_ctl;

    // Heap engine status.
    typedef struct packed {
        logic done;
        logic busy;
    } t_heap_sts;

endpackage

FILE: rtl/core/hcb_heap.sv
// Binary min-heap engine: slot memory with push and pop sift sequencing.
module hcb_heap
    import hcb_pkg::*;
#(
    parameter int MAX_SYM = MaxSymbols,
    parameter int HW      = WeightBits + $clog2(MaxSymbols),
    parameter int NB      = $clog2(2 * MaxSymbols - 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_heap_ctl                    i_ctl,
    input  logic [HW-1:0]                i_push_weight,
    input  logic [NB-1:0]                i_push_node,
    output t_heap_sts                    o_sts,
    output logic [HW-1:0]                o_top_weight,
    output logic [NB-1:0]                o_top_node,
    output logic [$clog2(MAX_SYM+1)-1:0] o_count
);

    localparam int SB = $clog2(MAX_SYM + 1);
    localparam int CW = SB + 1;
    localparam int EW = HW + NB;
    localparam int Depth = MAX_SYM + 1;

    typedef enum logic [2:0] {
        H_IDLE, H_PU_RD, H_PU_CMP, H_PO_LD, H_PO_RD, H_PO_CMP
    } t_hstate;

    t_hstate r_state, n_state;
    logic [SB-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_child, n_child;
    logic [EW-1:0] r_ent, n_ent;
    logic [EW-1:0] r_top, n_top;

    logic [EW-1:0] mem [Depth];
    logic [EW-1:0] r_rd_a, r_rd_b;
    logic [SB-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic          done;

    logic          sel_b;
    logic [EW-1:0] ch_ent;
    logic [CW-1:0] ch_pos;
    logic [CW-1:0] cnt_x;

    assign cnt_x = {1'b0, r_cnt};

    // Pick the smaller child; the right one only if the left is strictly greater.
    always_comb begin
        sel_b  = (r_child < cnt_x) && (r_rd_a[EW-1:NB] > r_rd_b[EW-1:NB]);
        ch_ent = sel_b ? r_rd_b : r_rd_a;
        ch_pos = sel_b ? r_child + CW'(1) : r_child;
    end

    // Sequence the sift steps.
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_child   = r_child;
        n_ent     = r_ent;
        n_top     = r_top;
        rd_a_addr = '0;
        rd_b_addr = '0;
        wr_en     = 1'b0;
        wr_addr   = r_pos[SB-1:0];
        wr_data   = r_ent;
        done      = 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_ctl.push) begin
                    n_cnt   = r_cnt + SB'(1);
                    n_pos   = cnt_x + CW'(1);
                    n_ent   = {i_push_weight, i_push_node};
                    n_state = H_PU_RD;
                end else if (i_ctl.pop) begin
                    rd_a_addr = SB'(1);
                    rd_b_addr = r_cnt;
                    n_state   = H_PO_LD;
                end
            end
            H_PU_RD: begin
                if (r_pos == CW'(1)) begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    rd_a_addr = r_pos[SB:1];
                    n_state   = H_PU_CMP;
                end
            end
            H_PU_CMP: begin
                wr_en = 1'b1;
                if (r_ent[EW-1:NB] < r_rd_a[EW-1:NB]) begin
                    wr_data = r_rd_a;
                    n_pos   = r_pos >> 1;
                    n_state = H_PU_RD;
                end else begin
                    done    = 1'b1;
                    n_state = H_IDLE;
                end
            end
            H_PO_LD: begin
                n_top   = r_rd_a;
                n_ent   = r_rd_b;
                n_cnt   = r_cnt - SB'(1);
                n_pos   = CW'(1);
                n_child = CW'(2);
                n_state = H_PO_RD;
            end
            H_PO_RD: begin
                if (r_child > cnt_x) begin
                    wr_en   = 1'b1;
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    rd_a_addr = r_child[SB-1:0];
                    rd_b_addr = SB'(r_child + CW'(1));
                    n_state   = H_PO_CMP;
                end
            end
            H_PO_CMP: begin
                wr_en = 1'b1;
                if (r_ent[EW-1:NB] <= ch_ent[EW-1:NB]) begin
                    done    = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    wr_data = ch_ent;
                    n_pos   = ch_pos;
                    n_child = ch_pos << 1;
                    n_state = H_PO_RD;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    // Hold control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos   <= n_pos;
        r_child <= n_child;
        r_ent   <= n_ent;
        r_top   <= n_top;
    end

    // Slot memory: one write, two registered reads.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_a_addr];
        r_rd_b <= mem[rd_b_addr];
    end

    assign o_sts.done   = done;
    assign o_sts.busy   = (r_state != H_IDLE);
    assign o_top_weight = r_top[EW-1:NB];
    assign o_top_node   = r_top[NB-1:0];
    assign o_count      = r_cnt;

`include "huffman_code_builder_core_assert.svh"

    `HCB_ASSERT(a_cnt_cap, {1'b0, r_cnt} <= CW'(MAX_SYM), "heap count above capacity")
    `HCB_NEVER(a_req_busy, (r_state != H_IDLE) && (i_ctl.push || i_ctl.pop), "request while busy")
    `HCB_NEVER(a_pop_empty, (r_state == H_IDLE) && i_ctl.pop && (r_cnt == '0), "pop of empty heap")

endmodule

FILE: rtl/core/huffman_code_builder_core.sv
// Huffman code builder: takes (symbol, weight) transactions and returns one
// code per leaf.
//
// Input channel i_in_valid / o_in_stall / i_in_data carries pairs. Each pair
// is stored as a leaf and pushed into a min-heap, rising one level at a
// time. The pair flagged last_symbol then starts the build: pairs of
// minima are popped and their sum pushed back, each merge costing three
// heap operations. The tree walk then visits each node depth first,
// stacking right branches, and emits each leaf. All heap operations run
// through the heap slot memory, one sift level at a time.
// Output channel o_out_valid / i_out_stall / o_out_data carries one result
// per leaf in depth-first order, last_code on the final one. A result sits
// in an output register; while the receiver stalls, the walk waits on the
// next leaf and the input stays stalled until the walk ends.
// Pairs beyond MAX_SYM are dropped and flag overflow on the run's results.
// Reset (synchronous, active low) empties the heap and the node count; the
// memories hold no reset and are written before they are read.
module huffman_code_builder_core
    import hcb_pkg::*;
#(
    parameter int MAX_SYM = MaxSymbols
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int NCap = 2 * MAX_SYM - 1;
    localparam int NB   = $clog2(NCap);
    localparam int HW   = WeightBits + $clog2(MAX_SYM);
    localparam int SB   = $clog2(MAX_SYM + 1);
    localparam int AB   = $clog2(MAX_SYM);
    localparam int NDW  = 1 + 2 * NB + SymBits;
    localparam int STW  = NB + LenBits + CodeBits;

    typedef enum logic [3:0] {
        S_IN, S_PUSH, S_MCHK, S_POPA, S_ISSB, S_POPB, S_MNEW, S_ROOT,
        S_WRD, S_WEVAL, S_WPOP
    } t_state;

    t_state r_state, n_state;
    logic [NB-1:0]       r_nc, n_nc;
    logic                r_drop, n_drop;
    logic                r_last, n_last;
    logic [SB-1:0]       r_sp, n_sp;
    logic [HW+NB-1:0]    r_a, n_a;
    logic [HW+NB-1:0]    r_b, n_b;
    logic [NB-1:0]       r_cur_node, n_cur_node;
    logic [LenBits-1:0]  r_cur_d, n_cur_d;
    logic [CodeBits-1:0] r_cur_code, n_cur_code;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    t_heap_ctl     h_ctl;
    t_heap_sts     h_sts;
    logic [HW-1:0] h_push_w, h_top_w;
    logic [NB-1:0] h_push_n, h_top_n;
    logic [SB-1:0] h_cnt;

    // Node memory: {is_leaf, left, right, symbol}.
    logic [NDW-1:0] nd_mem [NCap];
    logic [NDW-1:0] r_nd_rd;
    logic           nd_we;
    logic [NB-1:0]  nd_waddr;
    logic [NDW-1:0] nd_wdata;

    // Walk stack memory: {node, depth, code}.
    logic [STW-1:0] st_mem [MAX_SYM];
    logic [STW-1:0] r_st_rd;
    logic           st_we;
    logic [AB-1:0]  st_raddr;

    logic                nd_leaf;
    logic [NB-1:0]       nd_left, nd_right;
    logic [SymBits-1:0]  nd_sym;
    logic [LenBits-1:0]  d_next;
    logic [CodeBits-1:0] code_next;

    assign nd_leaf   = r_nd_rd[NDW-1];
    assign nd_left   = r_nd_rd[NDW-2 -: NB];
    assign nd_right  = r_nd_rd[SymBits+NB-1 -: NB];
    assign nd_sym    = r_nd_rd[SymBits-1:0];
    assign d_next    = r_cur_d + LenBits'(1);
    assign code_next = r_cur_code << 1;

    hcb_heap #(
        .MAX_SYM (MAX_SYM),
        .HW      (HW),
        .NB      (NB)
    ) u_heap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (h_ctl),
        .i_push_weight (h_push_w),
        .i_push_node   (h_push_n),
        .o_sts         (h_sts),
        .o_top_weight  (h_top_w),
        .o_top_node    (h_top_n),
        .o_count       (h_cnt)
    );

    // Sequence intake, merges and the tree walk.
    always_comb begin
        n_state     = r_state;
        n_nc        = r_nc;
        n_drop      = r_drop;
        n_last      = r_last;
        n_sp        = r_sp;
        n_a         = r_a;
        n_b         = r_b;
        n_cur_node  = r_cur_node;
        n_cur_d     = r_cur_d;
        n_cur_code  = r_cur_code;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        h_ctl       = '0;
        h_push_w    = HW'(i_in_data.weight);
        h_push_n    = r_nc;
        nd_we       = 1'b0;
        nd_waddr    = r_nc;
        nd_wdata    = {1'b1, {(2 * NB){1'b0}}, i_in_data.symbol};
        st_we       = 1'b0;
        st_raddr    = AB'(r_sp - SB'(1));
        case (r_state)
            S_IN: begin
                if (i_in_valid) begin
                    n_last = i_in_data.last_symbol;
                    if ({1'b0, r_nc} < (NB + 1)'(MAX_SYM)) begin
                        nd_we      = 1'b1;
                        h_ctl.push = 1'b1;
                        n_nc       = r_nc + NB'(1);
                        n_state    = S_PUSH;
                    end else begin
                        n_drop = 1'b1;
                        if (i_in_data.last_symbol) begin
                            n_state = S_MCHK;
                        end
                    end
                end
            end
            S_PUSH: begin
                if (h_sts.done) begin
                    n_state = r_last ? S_MCHK : S_IN;
                end
            end
            S_MCHK: begin
                h_ctl.pop = 1'b1;
                n_state   = (h_cnt > SB'(1)) ? S_POPA : S_ROOT;
            end
            S_POPA: begin
                if (h_sts.done) begin
                    n_a     = {h_top_w, h_top_n};
                    n_state = S_ISSB;
                end
            end
            S_ISSB: begin
                h_ctl.pop = 1'b1;
                n_state   = S_POPB;
            end
            S_POPB: begin
                if (h_sts.done) begin
                    n_b     = {h_top_w, h_top_n};
                    n_state = S_MNEW;
                end
            end
            S_MNEW: begin
                // Join the two minima under a new node and push it back.
                nd_we      = 1'b1;
                nd_wdata   = {1'b0, r_a[NB-1:0], r_b[NB-1:0], {SymBits{1'b0}}};
                h_ctl.push = 1'b1;
                h_push_w   = r_a[HW+NB-1:NB] + r_b[HW+NB-1:NB];
                n_nc       = r_nc + NB'(1);
                n_state    = S_PUSH;
            end
            S_ROOT: begin
                if (h_sts.done) begin
                    n_cur_node = h_top_n;
                    n_cur_d    = '0;
                    n_cur_code = '0;
                    n_sp       = '0;
                    n_state    = S_WRD;
                end
            end
            S_WRD: begin
                n_state = S_WEVAL;
            end
            S_WEVAL: begin
                if (nd_leaf) begin
                    if (!(r_out_valid && i_out_stall)) begin
                        n_out_valid       = 1'b1;
                        n_out.out_symbol  = nd_sym;
                        n_out.code_length = r_cur_d;
                        n_out.code_bits   = r_cur_code;
                        n_out.last_code   = (r_sp == '0);
                        n_out.overflow    = r_drop;
                        if (r_sp == '0) begin
                            n_nc    = '0;
                            n_drop  = 1'b0;
                            n_last  = 1'b0;
                            n_state = S_IN;
                        end else begin
                            n_sp    = r_sp - SB'(1);
                            n_state = S_WPOP;
                        end
                    end
                end else begin
                    // Stack the right branch, descend left.
                    st_we      = 1'b1;
                    n_sp       = r_sp + SB'(1);
                    n_cur_node = nd_left;
                    n_cur_d    = d_next;
                    n_cur_code = code_next | CodeBits'(1);
                    n_state    = S_WRD;
                end
            end
            S_WPOP: begin
                n_cur_node = r_st_rd[STW-1 -: NB];
                n_cur_d    = r_st_rd[CodeBits+LenBits-1 -: LenBits];
                n_cur_code = r_st_rd[CodeBits-1:0];
                n_state    = S_WRD;
            end
            default: n_state = S_IN;
        endcase
    end

    // Hold control state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IN;
            r_nc        <= '0;
            r_drop      <= 1'b0;
            r_last      <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nc        <= n_nc;
            r_drop      <= n_drop;
            r_last      <= n_last;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_cur_node <= n_cur_node;
        r_cur_d    <= n_cur_d;
        r_cur_code <= n_cur_code;
        r_out      <= n_out;
    end

    // Node memory.
    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            nd_mem[nd_waddr] <= nd_wdata;
        end
        r_nd_rd <= nd_mem[r_cur_node];
    end

    // Walk stack memory.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[r_sp[AB-1:0]] <= {nd_right, d_next, code_next};
        end
        r_st_rd <= st_mem[st_raddr];
    end

    assign o_in_stall  = (r_state != S_IN);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "huffman_code_builder_core_assert.svh"

    `HCB_ASSERT(a_nc_cap, {1'b0, r_nc} <= (NB + 1)'(NCap), "node count above capacity")
    `HCB_ASSERT(a_sp_cap, r_sp <= SB'(MAX_SYM), "walk stack overflow")
    `HCB_NEVER(a_walk_heap, (r_state == S_WEVAL) && (h_cnt != '0), "heap not empty during walk")

endmodule
